FILE: sv/plob_pkg.sv
package plob_pkg;

  // Default depth of each side's level table.
  localparam int LEVELS_DEF = 64;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 40;
  localparam int ORD_W   = 32;
  localparam int ENTRY_W = PRICE_W + QTY_W;

  localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

  // Status codes carried with every result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_DELETE  = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_REPLACE = 2'd3
  } op_t;

  // A classified command as it waits in the queue between front and back.
  typedef struct packed {
    op_t                op;
    logic               side;
    logic               same_price;
    logic [PRICE_W-1:0] price;
    logic [ORD_W-1:0]   qty;
    logic [ORD_W-1:0]   red;
    logic [ORD_W-1:0]   amount;
    logic [PRICE_W-1:0] new_price;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_DECIDE,
    S_WR2,
    S_DROP_RD,
    S_DROP_WR,
    S_BEST,
    S_OUT
  } state_t;

endpackage

FILE: sv/plob_front.sv
module plob_front import plob_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // price, qty, amount, new_price from bit 0 up
  input  logic [4*ORD_W-1:0]   s_axis_tdata,
  // command, side from bit 0 up
  input  logic [2:0]           s_axis_tuser,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  cmd_t       fifo [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // Classify the incoming beat and work out the reduction a cancel applies.
  always_comb begin
    dec.op         = op_t'(s_axis_tuser[1:0]);
    dec.side       = s_axis_tuser[2];
    dec.price      = s_axis_tdata[31:0];
    dec.qty        = s_axis_tdata[63:32];
    dec.amount     = s_axis_tdata[95:64];
    dec.new_price  = s_axis_tdata[127:96];
    dec.same_price = (dec.price == dec.new_price);
    if (dec.op == OP_CANCEL && dec.amount < dec.qty) begin
      dec.red = dec.amount;
    end else begin
      dec.red = dec.qty;
    end
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign cmd_valid     = (cnt != 2'd0);
  assign cmd           = fifo[rp];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid && cmd_ready;

  // Two-entry queue so that the back end and the input stall independently.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= dec;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/plob_back.sv
module plob_back import plob_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF,
  localparam int IW = $clog2(LEVELS),
  localparam int CW = $clog2(LEVELS + 1),
  localparam int OW = ((2 * PRICE_W + 2 * QTY_W + 2 * CW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [OW-1:0] m_axis_tdata,
  output logic [1:0]    m_axis_tuser
);

  // Level store: both sides in one memory, side bit on top of the address.
  logic [ENTRY_W-1:0] mem [2**(IW+1)];
  logic [ENTRY_W-1:0] rd_data;
  logic [IW:0]        rd_addr;
  logic               rd_en;
  logic               we;
  logic [IW:0]        wa;
  logic [ENTRY_W-1:0] wd;

  state_t state, state_next;
  cmd_t   cur;

  logic [CW-1:0]      ci;
  logic               sv;
  logic [IW-1:0]      sidx;
  logic               f_hit, g_hit;
  logic [IW-1:0]      f_idx, g_idx;
  logic [QTY_W-1:0]   f_qty, g_qty;
  logic [CW-1:0]      n_bid, n_ask;
  logic [PRICE_W-1:0] bb_p, ba_p;
  logic [QTY_W-1:0]   bb_q, ba_q;
  logic [1:0]         st;
  logic [IW-1:0]      p2_idx;
  logic [ENTRY_W-1:0] p2_data;
  logic               drop_en;
  logic               best_any;
  logic [PRICE_W-1:0] best_p;
  logic [QTY_W-1:0]   best_q;
  logic               m_valid;
  logic [OW-1:0]      m_data;
  logic [1:0]         m_user;

  logic [CW-1:0]      n_side;
  logic [CW-1:0]      n_m1;
  logic               full_n;
  logic               issue;
  logic               scan_done;
  logic               out_load;
  logic [PRICE_W-1:0] rd_p;
  logic [QTY_W-1:0]   rd_q;

  // Decision terms.
  logic [QTY_W:0]     add_sum;
  logic [QTY_W-1:0]   add_sat;
  logic               dropped;
  logic [QTY_W-1:0]   diff;
  logic [QTY_W:0]     rep_sum;
  logic [QTY_W-1:0]   rep_sat;
  logic [QTY_W:0]     g_sum;
  logic [QTY_W-1:0]   g_sat;
  logic [1:0]         d_st;
  logic               w1_en;
  logic [IW-1:0]      w1_idx;
  logic [ENTRY_W-1:0] w1_data;
  logic               d_p2_en;
  logic [IW-1:0]      d_p2_idx;
  logic [ENTRY_W-1:0] d_p2_data;
  logic               d_drop;
  logic               d_inc;

  assign n_side    = cur.side ? n_ask : n_bid;
  assign n_m1      = n_side - CW'(1);
  assign full_n    = (n_side == CW'(LEVELS));
  assign rd_p      = rd_data[ENTRY_W-1:QTY_W];
  assign rd_q      = rd_data[QTY_W-1:0];
  assign issue     = (state == S_FIND || state == S_BEST) && (ci < n_side);
  assign scan_done = !issue && !sv;
  assign out_load  = (state == S_OUT) && (!m_valid || m_axis_tready);

  // Memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Saturating sums and the reduction compare for the located level.
  always_comb begin
    add_sum = {1'b0, f_qty} + {{(QTY_W - ORD_W + 1){1'b0}}, cur.qty};
    add_sat = add_sum[QTY_W] ? QTY_MAX : add_sum[QTY_W-1:0];
    dropped = ({{(QTY_W - ORD_W){1'b0}}, cur.red} >= f_qty);
    diff    = f_qty - {{(QTY_W - ORD_W){1'b0}}, cur.red};
    rep_sum = {1'b0, diff} + {{(QTY_W - ORD_W + 1){1'b0}}, cur.amount};
    rep_sat = rep_sum[QTY_W] ? QTY_MAX : rep_sum[QTY_W-1:0];
    g_sum   = {1'b0, g_qty} + {{(QTY_W - ORD_W + 1){1'b0}}, cur.amount};
    g_sat   = g_sum[QTY_W] ? QTY_MAX : g_sum[QTY_W-1:0];
  end

  // Plan the table update once both prices have been searched for.
  always_comb begin
    d_st      = ST_OK;
    w1_en     = 1'b0;
    w1_idx    = f_idx;
    w1_data   = {cur.price, diff};
    d_p2_en   = 1'b0;
    d_p2_idx  = f_idx;
    d_p2_data = {cur.new_price, {(QTY_W - ORD_W){1'b0}}, cur.amount};
    d_drop    = 1'b0;
    d_inc     = 1'b0;
    unique case (cur.op)
      OP_ADD: begin
        if (f_hit) begin
          w1_en   = 1'b1;
          w1_data = {cur.price, add_sat};
        end else if (full_n) begin
          d_st = ST_FULL;
        end else begin
          w1_en   = 1'b1;
          w1_idx  = n_side[IW-1:0];
          w1_data = {cur.price, {(QTY_W - ORD_W){1'b0}}, cur.qty};
          d_inc   = 1'b1;
        end
      end
      OP_DELETE, OP_CANCEL: begin
        if (!f_hit) begin
          d_st = ST_NOTFOUND;
        end else if (!dropped) begin
          w1_en = 1'b1;
        end else begin
          d_drop = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (!f_hit) begin
          d_st = ST_NOTFOUND;
        end else if (cur.same_price) begin
          // The level is reduced and topped up, or dropped and re-created.
          w1_en   = 1'b1;
          w1_data = dropped ? {cur.price, {(QTY_W - ORD_W){1'b0}}, cur.amount}
                            : {cur.price, rep_sat};
        end else if (g_hit) begin
          w1_en   = 1'b1;
          w1_idx  = g_idx;
          w1_data = {cur.new_price, g_sat};
          if (dropped) begin
            d_drop = 1'b1;
          end else begin
            d_p2_en   = 1'b1;
            d_p2_data = {cur.price, diff};
          end
        end else if (!dropped && full_n) begin
          d_st = ST_FULL;
        end else if (dropped) begin
          // The new level takes the slot of the one that emptied.
          w1_en   = 1'b1;
          w1_data = {cur.new_price, {(QTY_W - ORD_W){1'b0}}, cur.amount};
        end else begin
          w1_en    = 1'b1;
          d_p2_en  = 1'b1;
          d_p2_idx = n_side[IW-1:0];
          d_inc    = 1'b1;
        end
      end
      default: begin
        d_st = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (cmd_valid) state_next = S_FIND;
      S_FIND:    if (scan_done) state_next = S_DECIDE;
      S_DECIDE: begin
        if (d_st != ST_OK) state_next = S_OUT;
        else if (d_p2_en) state_next = S_WR2;
        else if (d_drop) state_next = S_DROP_RD;
        else state_next = S_BEST;
      end
      S_WR2:     state_next = S_BEST;
      S_DROP_RD: state_next = S_DROP_WR;
      S_DROP_WR: state_next = S_BEST;
      S_BEST:    if (scan_done) state_next = S_OUT;
      S_OUT:     if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port and handshake controls per state.
  always_comb begin
    cmd_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {cur.side, ci[IW-1:0]};
    we        = 1'b0;
    wa        = {cur.side, w1_idx};
    wd        = w1_data;
    unique case (state)
      S_IDLE:  cmd_ready = 1'b1;
      S_FIND, S_BEST: rd_en = issue;
      S_DECIDE: we = w1_en && (d_st == ST_OK);
      S_WR2: begin
        we = 1'b1;
        wa = {cur.side, p2_idx};
        wd = p2_data;
      end
      S_DROP_RD: begin
        rd_en   = 1'b1;
        rd_addr = {cur.side, n_m1[IW-1:0]};
      end
      S_DROP_WR: begin
        // The last level moves into the hole left by the dropped one.
        we = 1'b1;
        wa = {cur.side, f_idx};
        wd = rd_data;
      end
      S_OUT: cmd_ready = 1'b0;
      default: cmd_ready = 1'b0;
    endcase
  end

  // State, counts and scan registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      n_bid   <= '0;
      n_ask   <= '0;
      bb_p    <= '0;
      bb_q    <= '0;
      ba_p    <= '0;
      ba_q    <= '0;
      m_valid <= 1'b0;
      sv      <= 1'b0;
      ci      <= '0;
    end else begin
      state <= state_next;
      if (out_load) m_valid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_valid <= 1'b0;

      // Read pipeline shared by both scans.
      sv <= issue;
      if (issue) begin
        ci   <= ci + CW'(1);
        sidx <= ci[IW-1:0];
      end

      unique case (state)
        S_IDLE: begin
          cur   <= cmd;
          ci    <= '0;
          f_hit <= 1'b0;
          g_hit <= 1'b0;
        end
        S_FIND: begin
          if (sv && rd_p == cur.price) begin
            f_hit <= 1'b1;
            f_idx <= sidx;
            f_qty <= rd_q;
          end
          if (sv && rd_p == cur.new_price) begin
            g_hit <= 1'b1;
            g_idx <= sidx;
            g_qty <= rd_q;
          end
        end
        S_DECIDE: begin
          st       <= d_st;
          p2_idx   <= d_p2_idx;
          p2_data  <= d_p2_data;
          drop_en  <= d_drop;
          ci       <= '0;
          best_any <= 1'b0;
          if (d_st == ST_OK && d_inc) begin
            if (cur.side) n_ask <= n_ask + CW'(1);
            else n_bid <= n_bid + CW'(1);
          end
        end
        S_WR2: begin
          ci <= '0;
        end
        S_DROP_RD: begin
          ci <= '0;
        end
        S_DROP_WR: begin
          ci <= '0;
          if (cur.side) n_ask <= n_ask - CW'(1);
          else n_bid <= n_bid - CW'(1);
        end
        S_BEST: begin
          if (sv && (!best_any || (cur.side ? (rd_p < best_p) : (rd_p > best_p)))) begin
            best_any <= 1'b1;
            best_p   <= rd_p;
            best_q   <= rd_q;
          end
          if (scan_done) begin
            if (cur.side) begin
              ba_p <= best_any ? best_p : '0;
              ba_q <= best_any ? best_q : '0;
            end else begin
              bb_p <= best_any ? best_p : '0;
              bb_q <= best_any ? best_q : '0;
            end
          end
        end
        S_OUT: begin
          ci <= '0;
        end
        default: begin
          ci <= '0;
        end
      endcase
    end
  end

  // Output register for the result beat.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_data <= OW'({n_ask, n_bid, ba_q, ba_p, bb_q, bb_p});
      m_user <= st;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tuser  = m_user;

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (n_bid <= CW'(LEVELS)) && (n_ask <= CW'(LEVELS)))
    else $error("level count beyond table depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_load && st == ST_FULL) |-> (n_side == CW'(LEVELS)))
    else $error("side reported full while it has room");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND || state == S_BEST) |-> (ci <= n_side))
    else $error("scan index ran past the occupied levels");

  a_drop_follows_plan: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP_RD) |-> (drop_en && n_side != '0))
    else $error("level removal without a planned drop");

endmodule

FILE: sv/price_level_order_book.sv
// Each result beat follows a sweep over the command's side of the level memory
// to locate the prices, up to two table writes and a second sweep to find the
// new best level, both sweeps through one read port; a refused command skips
// the writes and the second sweep. The back end takes one command at a time;
// a two-beat queue takes input while it works. Reset (rst, synchronous) empties
// both sides.
module price_level_order_book import plob_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF,
  localparam int CW = $clog2(LEVELS + 1),
  localparam int OW = ((2 * PRICE_W + 2 * QTY_W + 2 * CW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // price, qty, amount, new_price from bit 0 up
  input  logic [127:0]  s_axis_tdata,
  // command, side from bit 0 up
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // best_bid_price, best_bid_qty, best_ask_price, best_ask_qty, bid_count,
  // ask_count from bit 0 up, zero padded
  output logic [OW-1:0] m_axis_tdata,
  // status
  output logic [1:0]    m_axis_tuser
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  plob_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  plob_back #(.LEVELS(LEVELS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: tb/price_level_order_book_test.sv
module price_level_order_book_test;
  import plob_pkg::*;

  localparam int DEPTH     = LEVELS_DEF;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_W     = ((2 * PRICE_W + 2 * QTY_W + 2 * CNT_W + 7) / 8) * 8;
  localparam bit SIDE_BID  = 1'b0;
  localparam bit SIDE_ASK  = 1'b1;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 2 * DEPTH + 40;

  // Fields from the top bit down, matching the result beat with status below it.
  typedef struct packed {
    logic [CNT_W-1:0]   ask_count;
    logic [CNT_W-1:0]   bid_count;
    logic [QTY_W-1:0]   ask_qty;
    logic [PRICE_W-1:0] ask_price;
    logic [QTY_W-1:0]   bid_qty;
    logic [PRICE_W-1:0] bid_price;
    logic [1:0]         status;
  } book_view_t;

  typedef struct {
    op_t        op;
    bit         side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] amount;
    logic [31:0] new_price;
    bit         typed;
    book_view_t view;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [127:0]         s_axis_tdata = '0;
  logic [2:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  price_level_order_book dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of both level tables.
  logic [PRICE_W-1:0] lvl_price [2][DEPTH];
  logic [QTY_W-1:0]   lvl_qty   [2][DEPTH];
  int                 lvl_used  [2];

  book_view_t pending_views[$];
  int         mismatches = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;

  function automatic int find_level(bit s, logic [31:0] p);
    for (int i = 0; i < lvl_used[s]; i++)
      if (lvl_price[s][i] == p) return i;
    return -1;
  endfunction

  function automatic void drop_level(bit s, int i);
    for (int j = i; j < lvl_used[s] - 1; j++) begin
      lvl_price[s][j] = lvl_price[s][j+1];
      lvl_qty[s][j]   = lvl_qty[s][j+1];
    end
    lvl_used[s]--;
  endfunction

  function automatic void reduce_level(bit s, int i, logic [QTY_W-1:0] r);
    if (r < lvl_qty[s][i]) lvl_qty[s][i] = lvl_qty[s][i] - r;
    else drop_level(s, i);
  endfunction

  function automatic logic [1:0] add_level(bit s, logic [31:0] p, logic [31:0] q);
    int f;
    int pos;
    logic [QTY_W:0] sum;
    f = find_level(s, p);
    if (f >= 0) begin
      sum = lvl_qty[s][f] + q;
      lvl_qty[s][f] = sum[QTY_W] ? QTY_MAX : sum[QTY_W-1:0];
      return ST_OK;
    end
    if (lvl_used[s] >= DEPTH) return ST_FULL;
    pos = lvl_used[s];
    for (int i = 0; i < lvl_used[s]; i++)
      if (s ? lvl_price[s][i] >= p : lvl_price[s][i] <= p) begin
        pos = i;
        break;
      end
    for (int j = lvl_used[s]; j > pos; j--) begin
      lvl_price[s][j] = lvl_price[s][j-1];
      lvl_qty[s][j]   = lvl_qty[s][j-1];
    end
    lvl_price[s][pos] = p;
    lvl_qty[s][pos]   = q;
    lvl_used[s]++;
    return ST_OK;
  endfunction

  // Applies one command to the shadow book and returns the view it leaves.
  function automatic book_view_t apply_command(op_t op, bit s, logic [31:0] p,
                                               logic [31:0] q, logic [31:0] a,
                                               logic [31:0] np);
    book_view_t v;
    logic [1:0] st;
    int f;
    int n0;
    logic [PRICE_W-1:0] keep_price [DEPTH];
    logic [QTY_W-1:0]   keep_qty   [DEPTH];
    st = ST_OK;
    if (op == OP_ADD) begin
      st = add_level(s, p, q);
    end else begin
      f = find_level(s, p);
      if (f < 0) begin
        st = ST_NOTFOUND;
      end else if (op == OP_DELETE) begin
        reduce_level(s, f, q);
      end else if (op == OP_CANCEL) begin
        reduce_level(s, f, (a < q) ? a : q);
      end else begin
        n0 = lvl_used[s];
        for (int i = 0; i < DEPTH; i++) begin
          keep_price[i] = lvl_price[s][i];
          keep_qty[i]   = lvl_qty[s][i];
        end
        reduce_level(s, f, q);
        st = add_level(s, np, a);
        if (st != ST_OK) begin
          for (int i = 0; i < DEPTH; i++) begin
            lvl_price[s][i] = keep_price[i];
            lvl_qty[s][i]   = keep_qty[i];
          end
          lvl_used[s] = n0;
        end
      end
    end
    v.bid_price = lvl_used[0] ? lvl_price[0][0] : '0;
    v.bid_qty   = lvl_used[0] ? lvl_qty[0][0] : '0;
    v.ask_price = lvl_used[1] ? lvl_price[1][0] : '0;
    v.ask_qty   = lvl_used[1] ? lvl_qty[1][0] : '0;
    v.bid_count = CNT_W'(lvl_used[0]);
    v.ask_count = CNT_W'(lvl_used[1]);
    v.status    = st;
    return v;
  endfunction

  // Drives one command beat and records its expected view once accepted.
  task automatic send_command(op_t op, bit s, logic [31:0] p, logic [31:0] q,
                              logic [31:0] a, logic [31:0] np, bit typed,
                              book_view_t typed_view);
    book_view_t v;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {np, a, q, p};
    s_axis_tuser  <= {s, op};
    do @(posedge clk); while (!s_axis_tready);
    v = apply_command(op, s, p, q, a, np);
    pending_views.push_back(typed ? typed_view : v);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // Draws a price: mostly one already on the side, else from a small pool or at random.
  function automatic logic [31:0] pick_price(bit s);
    int r;
    r = $urandom_range(99);
    if (r < 60 && lvl_used[s] > 0) return lvl_price[s][$urandom_range(lvl_used[s] - 1)];
    if (r < 90) return 32'd1000 + $urandom_range(80);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_qty();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(20);
    if (r < 80) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_random();
    op_t op;
    bit s;
    int r;
    r = $urandom_range(99);
    op = (r < 40) ? OP_ADD : (r < 60) ? OP_DELETE : (r < 80) ? OP_CANCEL : OP_REPLACE;
    s = $urandom_range(1);
    send_command(op, s, pick_price(s), pick_qty(), pick_qty(), pick_price(s), 1'b0, '0);
  endtask

  // Result side: compare each beat with the oldest expectation, stall at random.
  always @(posedge clk) begin
    book_view_t got;
    book_view_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2*PRICE_W+2*QTY_W+2*CNT_W-1:0], m_axis_tuser};
        if (pending_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %h", got);
        end else begin
          want = pending_views.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected bid %h/%h ask %h/%h cnt %0d/%0d st %0d, got bid %h/%h ask %h/%h cnt %0d/%0d st %0d",
                       want.bid_price, want.bid_qty, want.ask_price, want.ask_qty,
                       want.bid_count, want.ask_count, want.status,
                       got.bid_price, got.bid_qty, got.ask_price, got.ask_qty,
                       got.bid_count, got.ask_count, got.status);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("price_level_order_book_test: FAIL");
      $finish;
    end
  end

  stim_row_t rows[$];

  function automatic book_view_t mk_view(logic [31:0] bp, logic [39:0] bq, logic [31:0] ap,
                                         logic [39:0] aq, int bc, int ac, logic [1:0] st);
    book_view_t v;
    v.bid_price = bp;
    v.bid_qty   = bq;
    v.ask_price = ap;
    v.ask_qty   = aq;
    v.bid_count = bc[CNT_W-1:0];
    v.ask_count = ac[CNT_W-1:0];
    v.status    = st;
    return v;
  endfunction

  function automatic void row(op_t op, bit s, logic [31:0] p, logic [31:0] q,
                              logic [31:0] a, logic [31:0] np, bit typed, book_view_t v);
    rows.push_back('{op, s, p, q, a, np, typed, v});
  endfunction

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle  = '{0, 66, 0, 34};
    phase_stall = '{0, 0, 66, 34};
    lvl_used = '{0, 0};

    // Directed table; typed views are obvious from the command alone.
    row(OP_DELETE,  SIDE_BID, 100, 1, 0, 0, 1, mk_view(0, 0, 0, 0, 0, 0, ST_NOTFOUND));
    row(OP_ADD,     SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1,
        mk_view(32'hFFFF_FFFF, 40'hFF_FFFF_FFFF >> 8, 0, 0, 1, 0, ST_OK));
    row(OP_ADD,     SIDE_ASK, 0, 0, 0, 0, 1,
        mk_view(32'hFFFF_FFFF, 40'h00_FFFF_FFFF, 0, 0, 1, 1, ST_OK));
    row(OP_ADD,     SIDE_BID, 50, 10, 0, 0, 0, '0);
    row(OP_ADD,     SIDE_BID, 50, 5, 0, 0, 0, '0);
    row(OP_CANCEL,  SIDE_BID, 50, 10, 3, 0, 0, '0);
    row(OP_CANCEL,  SIDE_BID, 50, 4, 9, 0, 0, '0);
    row(OP_DELETE,  SIDE_BID, 50, 100, 0, 0, 0, '0);
    row(OP_REPLACE, SIDE_ASK, 0, 0, 7, 200, 0, '0);
    row(OP_REPLACE, SIDE_ASK, 999, 1, 1, 5, 0, '0);
    row(OP_CANCEL,  SIDE_ASK, 200, 7, 7, 0, 0, '0);
    row(OP_ADD,     SIDE_ASK, 32'hFFFF_FFFF, 1, 0, 0, 0, '0);
    row(OP_ADD,     SIDE_ASK, 0, 32'hFFFF_FFFF, 0, 0, 0, '0);
    row(OP_DELETE,  SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, '0);
    row(OP_REPLACE, SIDE_BID, 12345, 1, 1, 1, 0, '0);
    row(OP_ADD,     SIDE_BID, 0, 0, 0, 0, 0, '0);
    row(OP_CANCEL,  SIDE_ASK, 0, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send_command(rows[i].op, rows[i].side, rows[i].price, rows[i].qty, rows[i].amount,
                   rows[i].new_price, rows[i].typed, rows[i].view);

    // Saturate one bid aggregate.
    repeat (260) send_command(OP_ADD, SIDE_BID, 32'd7, 32'hFFFF_FFFF, 0, 0, 1'b0, '0);
    send_command(OP_CANCEL, SIDE_BID, 32'd7, 32'hFFFF_FFFF, 32'd5, 0, 1'b0, '0);

    // Fill the ask side, then ask for a new level and a replace onto one.
    for (int i = 0; i < DEPTH + 2; i++)
      send_command(OP_ADD, SIDE_ASK, 32'd5000 + 3 * i, i, 0, 0, 1'b0, '0);
    send_command(OP_REPLACE, SIDE_ASK, 32'd5000, 32'd0, 32'd9, 32'd4, 1'b0, '0);
    send_command(OP_REPLACE, SIDE_ASK, 32'd5003, 32'd9, 32'd9, 32'd5006, 1'b0, '0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_command(OP_DELETE, SIDE_ASK, 32'd5000 + 3 * i, 32'hFFFF_FFFF, 0, 0, 1'b0, '0);

    // Random phases, with the sender held off until the book has drained.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      repeat (220) send_random();
      wait_drained();
    end

    stall_pct = 0;
    fork
      wait_drained();
      begin
        repeat (IDLE_LIMIT) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_views.size() == 0)
      $display("price_level_order_book_test: PASS");
    else
      $display("price_level_order_book_test: FAIL");
    $finish;
  end

endmodule
